/* hw/rtl/pulser_control_registers_assert.svh */
// Assertion macros shared by the pulse generator register block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef PULSER_CONTROL_REGISTERS_ASSERT_SVH
`define PULSER_CONTROL_REGISTERS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCR_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pcr assertion failed");

// Next-cycle implication, disabled during reset.
`define PCR_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pcr assertion failed");

`endif

/* hw/rtl/pcr_pkg.sv */
// Package of the pulse generator register block: codes, types and the
// duration and duty clamp functions. No dependencies.
package pcr_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam logic [15:0] WDOG_RESET = 16'd1000;
  localparam logic [15:0] TICK_MAX = 16'hffff;

  // Item kinds.
  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_CUT   = 3'd2;
  localparam logic [2:0] KIND_PROBE = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;
  localparam logic [2:0] KIND_FAULT = 3'd5;

  // Register addresses.
  localparam logic [7:0] A_CTRL  = 8'h01;
  localparam logic [7:0] A_MODE  = 8'h02;
  localparam logic [7:0] A_CURR  = 8'h03;
  localparam logic [7:0] A_DUR   = 8'h04;
  localparam logic [7:0] A_DUTY  = 8'h05;
  localparam logic [7:0] A_RES0  = 8'h08;
  localparam logic [7:0] A_RES1  = 8'h09;
  localparam logic [7:0] A_FAULT = 8'h10;

  // Cut window outcomes.
  localparam logic [1:0] OUT_OPEN  = 2'd0;
  localparam logic [1:0] OUT_SHORT = 2'd1;
  localparam logic [1:0] OUT_GOOD  = 2'd2;

  localparam logic [6:0] DUR_RESET  = 7'h42;
  localparam logic [7:0] DUTY_RESET = 8'd124;
  localparam logic [7:0] DUTY_MIN   = 8'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       exec;
    logic       div_step;
    logic [1:0] step_idx;
    logic       load;
  } pcr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_req;
  } pcr_status_t;

  // Effective exponent and fraction of a duration byte.
  function automatic logic [1:0] dur_exp(input logic [6:0] b);
    return (b[6:5] == 2'd3) ? 2'd2 : b[6:5];
  endfunction

  function automatic logic [4:0] dur_frac(input logic [6:0] b);
    return (b[4:0] > 5'd19) ? 5'd19 : b[4:0];
  endfunction

  // Duration in microseconds: f/2, 5f or 50f by exponent.
  function automatic logic [9:0] decode_us(input logic [6:0] b);
    logic [9:0] f;
    f = {5'd0, dur_frac(b)};
    case (dur_exp(b))
      2'd0: return f >> 1;
      2'd1: return (f << 2) + f;
      default: return (f << 5) + (f << 4) + (f << 1);
    endcase
  endfunction

  // Clamp the duration for the current setting and re-encode it canonically.
  function automatic logic [6:0] fix_dur(input logic high, input logic [6:0] b);
    logic [4:0] f;
    f = dur_frac(b);
    if (!high) begin
      return {2'd1, 5'd2};
    end
    case (dur_exp(b))
      2'd0: return {2'd1, 5'd5};
      2'd1: return (f >= 5'd5) ? {2'd1, f} : {2'd1, 5'd5};
      default: begin
        if (f == 5'd0) begin
          return {2'd1, 5'd5};
        end else if (f == 5'd1) begin
          return {2'd1, 5'd10};
        end else begin
          return {2'd2, f};
        end
      end
    endcase
  endfunction

  // Upper duty bound for the current and duration.
  function automatic logic [7:0] duty_hi(input logic high, input logic [6:0] b);
    if (!high) begin
      return 8'd22;
    end
    return (decode_us(b) >= 10'd100) ? 8'd124 : 8'd47;
  endfunction

  function automatic logic [7:0] clamp_duty(input logic [7:0] v, input logic [7:0] hi);
    if (v < DUTY_MIN) begin
      return DUTY_MIN;
    end
    return (v > hi) ? hi : v;
  endfunction

endpackage

/* hw/rtl/pcr_ctrl.sv */
// Controller of the pulse generator register block: sequences capture,
// execute, ratio division and output load. Depends on pcr_pkg and the assertion header.
`include "pulser_control_registers_assert.svh"

module pcr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  input  pcr_pkg::pcr_status_t status_i,
  output pcr_pkg::pcr_cmd_t  cmd_o
);
  import pcr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_LOAD = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       mvalid_q, mvalid_d;

  // Sequencing of one beat through the datapath.
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    mvalid_d = mvalid_q;
    cmd_o    = '0;
    cmd_o.step_idx = step_q;
    if (mvalid_q && m_ready_i) begin
      mvalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        step_d  = 2'd2;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!status_i.div_req) begin
          state_d = S_LOAD;
        end else begin
          cmd_o.div_step = 1'b1;
          if (step_q == 2'd0) begin
            state_d = S_LOAD;
          end else begin
            step_d = step_q - 2'd1;
          end
        end
      end
      S_LOAD: begin
        if (!mvalid_q || m_ready_i) begin
          cmd_o.load = 1'b1;
          mvalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= 2'd0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      mvalid_q <= mvalid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = mvalid_q;

  `PCR_ASSERT_NXT(a_accept_exec, s_valid_i && s_ready_o, state_q == S_EXEC)
  `PCR_ASSERT_NXT(a_exec_div, state_q == S_EXEC, state_q == S_DIV)
  `PCR_ASSERT_NXT(a_last_step_load, cmd_o.div_step && step_q == 2'd0, state_q == S_LOAD)

endmodule

/* hw/rtl/pcr_datapath.sv */
// Datapath of the pulse generator register block: item capture, register
// state, counters, ratio divider and output register. Depends on pcr_pkg.
module pcr_datapath #(
  parameter int unsigned CountWidth = pcr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcr_pkg::pcr_cmd_t   cmd_i,
  output pcr_pkg::pcr_status_t status_o,
  input  logic [23:0]         in_data_i,
  input  logic [2:0]          in_kind_i,
  input  logic [15:0]         timeout_i,
  output logic [31:0]         out_data_o
);
  import pcr_pkg::*;

  localparam int unsigned NW = CountWidth + 2;
  localparam int unsigned RW = CountWidth + 3;
  localparam int unsigned TW = CountWidth + 5;
  localparam logic [CountWidth-1:0] CNT_MAX = {CountWidth{1'b1}};

  // Captured item.
  logic [2:0] kind_q;
  logic [7:0] addr_q, wdata_q;
  logic [1:0] outc_q;
  logic       cond_q;

  // Block state.
  logic run_q, run_d, mode_q, mode_d, cur_q, cur_d;
  logic fault_q, fault_d, wd_q, wd_d, probe_q, probe_d;
  logic [6:0] dur_q, dur_d;
  logic [7:0] duty_q, duty_d, r1_q, r1_d, rd_q, rd_d;
  logic [15:0] ticks_q, ticks_d, ticks_inc;
  logic [CountWidth-1:0] open_q, open_d, short_q, short_d, good_q, good_d;

  // Ratio divider.
  logic [RW-1:0] rem_o_q, rem_o_d, rem_s_q, rem_s_d;
  logic [NW-1:0] div_n_q, div_n_d, n_sum;
  logic [2:0]    qo_q, qo_d, qs_q, qs_d;
  logic          res_div_q, res_div_d;
  logic [TW-1:0] trial, ext_o, ext_s;
  logic [31:0]   out_q;
  logic [7:0]    rd_final;

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= in_kind_i;
      addr_q  <= in_data_i[7:0];
      wdata_q <= in_data_i[15:8];
      outc_q  <= in_data_i[17:16];
      cond_q  <= in_data_i[18];
    end
  end

  assign n_sum = {2'b0, open_q} + {2'b0, short_q} + {2'b0, good_q};
  assign ticks_inc = (ticks_q < TICK_MAX) ? ticks_q + 16'd1 : ticks_q;
  assign trial = {3'b0, div_n_q} << cmd_i.step_idx;
  assign ext_o = {2'b0, rem_o_q};
  assign ext_s = {2'b0, rem_s_q};

  // Item execution and divider steps.
  always_comb begin
    run_d = run_q; mode_d = mode_q; cur_d = cur_q; fault_d = fault_q;
    wd_d = wd_q; probe_d = probe_q; dur_d = dur_q; duty_d = duty_q;
    r1_d = r1_q; rd_d = rd_q; ticks_d = ticks_q;
    open_d = open_q; short_d = short_q; good_d = good_q;
    rem_o_d = rem_o_q; rem_s_d = rem_s_q; div_n_d = div_n_q;
    qo_d = qo_q; qs_d = qs_q; res_div_d = res_div_q;
    if (cmd_i.exec) begin
      rd_d = 8'd0;
      res_div_d = 1'b0;
      case (kind_q)
        KIND_WRITE: begin
          if (addr_q == A_CTRL) begin
            if (!wdata_q[0]) begin
              run_d = 1'b0;
            end else if (!run_q && !fault_q) begin
              run_d = 1'b1;
              ticks_d = 16'd0;
              probe_d = 1'b0;
              open_d = '0; short_d = '0; good_d = '0;
            end
          end else if (addr_q == A_FAULT) begin
            if (wdata_q[1]) begin
              wd_d = 1'b0;
            end
          end else if (!run_q) begin
            case (addr_q)
              A_MODE: mode_d = wdata_q[0];
              A_CURR: begin
                cur_d  = (wdata_q > 8'd5);
                dur_d  = fix_dur(cur_d, dur_q);
                duty_d = clamp_duty(duty_q, duty_hi(cur_d, dur_d));
              end
              A_DUR: begin
                dur_d  = fix_dur(cur_q, wdata_q[6:0]);
                duty_d = clamp_duty(duty_q, duty_hi(cur_q, dur_d));
              end
              A_DUTY: duty_d = clamp_duty(wdata_q, duty_hi(cur_q, dur_q));
              default: ;
            endcase
          end
        end
        KIND_READ: begin
          case (addr_q)
            A_CTRL:  rd_d = {7'd0, run_q};
            A_MODE:  rd_d = {7'd0, mode_q};
            A_CURR:  rd_d = cur_q ? 8'd10 : 8'd1;
            A_DUR:   rd_d = {1'b0, dur_q};
            A_DUTY:  rd_d = duty_q;
            A_RES1:  rd_d = r1_q;
            A_FAULT: rd_d = {6'd0, wd_q, fault_q};
            A_RES0: begin
              ticks_d = 16'd0;
              if (!mode_q) begin
                rd_d = {fault_q, 6'd0, probe_q};
                r1_d = 8'd0;
              end else begin
                r1_d = (good_q > CountWidth'(255)) ? 8'd255 : good_q[7:0];
                open_d = '0; short_d = '0; good_d = '0;
                if (n_sum == '0) begin
                  rd_d = {fault_q, 1'b0, 3'd7, 3'd0};
                end else begin
                  res_div_d = 1'b1;
                  div_n_d = n_sum;
                  rem_o_d = {open_q, 3'b0} - {3'b0, open_q};
                  rem_s_d = {short_q, 3'b0} - {3'b0, short_q};
                  qo_d = 3'd0;
                  qs_d = 3'd0;
                end
              end
            end
            default: rd_d = 8'd0;
          endcase
        end
        KIND_CUT: begin
          if (run_q && mode_q) begin
            case (outc_q)
              OUT_OPEN:  if (open_q != CNT_MAX) open_d = open_q + 1'b1;
              OUT_SHORT: if (short_q != CNT_MAX) short_d = short_q + 1'b1;
              OUT_GOOD:  if (good_q != CNT_MAX) good_d = good_q + 1'b1;
              default: ;
            endcase
          end
        end
        KIND_PROBE: begin
          if (run_q && !mode_q && cond_q) begin
            probe_d = 1'b1;
            run_d = 1'b0;
          end
        end
        KIND_TICK: begin
          ticks_d = ticks_inc;
          if (run_q && ticks_inc >= timeout_i) begin
            wd_d = 1'b1;
            run_d = 1'b0;
          end
        end
        KIND_FAULT: begin
          fault_d = 1'b1;
          run_d = 1'b0;
        end
        default: ;
      endcase
    end
    // One restoring step per cycle for both ratios.
    if (cmd_i.div_step) begin
      if (ext_o >= trial) begin
        rem_o_d = RW'(ext_o - trial);
        qo_d[cmd_i.step_idx] = 1'b1;
      end
      if (ext_s >= trial) begin
        rem_s_d = RW'(ext_s - trial);
        qs_d[cmd_i.step_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; mode_q <= 1'b0; cur_q <= 1'b1; fault_q <= 1'b0;
      wd_q <= 1'b0; probe_q <= 1'b0; dur_q <= DUR_RESET; duty_q <= DUTY_RESET;
      r1_q <= 8'd0; ticks_q <= 16'd0;
      open_q <= '0; short_q <= '0; good_q <= '0;
      res_div_q <= 1'b0;
    end else begin
      run_q <= run_d; mode_q <= mode_d; cur_q <= cur_d; fault_q <= fault_d;
      wd_q <= wd_d; probe_q <= probe_d; dur_q <= dur_d; duty_q <= duty_d;
      r1_q <= r1_d; ticks_q <= ticks_d;
      open_q <= open_d; short_q <= short_d; good_q <= good_d;
      res_div_q <= res_div_d;
    end
  end

  // Divider and read payload registers.
  always_ff @(posedge clk_i) begin
    rem_o_q <= rem_o_d;
    rem_s_q <= rem_s_d;
    div_n_q <= div_n_d;
    qo_q    <= qo_d;
    qs_q    <= qs_d;
    rd_q    <= rd_d;
  end

  assign rd_final = res_div_q ? {fault_q, 1'b0, qo_q, qs_q} : rd_q;

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= {3'b0, duty_q, decode_us(dur_q), cur_q, mode_q, run_q, rd_final};
    end
  end

  assign out_data_o = out_q;
  assign status_o.div_req = res_div_q;

endmodule

/* hw/rtl/pulser_control_registers.sv */
// Top level of the pulse generator register block: stream ports, the APB
// configuration register, controller and datapath. Depends on pcr_pkg.

// One input beat yields one result beat. An item passes the execute, divide and
// load states after acceptance; for a cut mode RES0 read with windows counted,
// a restoring divider forms both ratio bits at one quotient bit a cycle. The
// input is taken again as soon as the item is in the output register. A result
// that waits there holds the next item at its load step, and the input stays
// closed until that load. APB register 0 at address 0 is the watchdog timeout
// in ticks; users must write it only while the block is idle, which is unchecked.
module pulser_control_registers #(
  parameter int unsigned COUNT_WIDTH = pcr_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_addr[7:0], write_data[15:8], window_outcome[17:16], probe_conducted[18]
  input  logic [23:0] s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], running[8], cut_mode[9], use_high_current[10],
  // pulse_duration_us[20:11], duty_code[28:21]
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pcr_pkg::*;

  pcr_cmd_t    cmd;
  pcr_status_t status;
  logic [15:0] timeout_q;

  // Watchdog timeout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= WDOG_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      timeout_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, timeout_q} : 32'd0;

  pcr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pcr_datapath #(
    .CountWidth (COUNT_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata),
    .in_kind_i  (s_axis_tuser),
    .timeout_i  (timeout_q),
    .out_data_o (m_axis_tdata)
  );

endmodule

/* test/tb_pulser_control_registers.sv */
// Self-checking testbench for the pulse generator register block.
// Drives item beats and APB writes, predicts every result beat in a scoreboard
// class and compares field by field. Depends on pcr_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_pulser_control_registers;
  import pcr_pkg::*;

  // One predicted result beat, last field in the lowest bits.
  typedef struct packed {
    logic [7:0] duty;
    logic [9:0] duration_us;
    logic       high_current;
    logic       cut_mode;
    logic       running;
    logic [7:0] read_data;
  } pulser_result_t;

  localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;

  // Register state model and queue of expected result beats.
  class pulser_scoreboard;
    pulser_result_t expected_q[$];
    int unsigned    mismatches;
    logic [15:0]    wdog_timeout;
    logic           run_flag, cut_mode, high_current, fault_sticky;
    logic           wdog_latched, probe_seen;
    logic [6:0]     dur_code;
    logic [7:0]     duty, res1_held;
    int unsigned    ticks, open_cnt, short_cnt, good_cnt;

    function new();
      mismatches   = 0;
      wdog_timeout = WDOG_RESET;
      run_flag     = 1'b0;
      cut_mode     = 1'b0;
      high_current = 1'b1;
      fault_sticky = 1'b0;
      wdog_latched = 1'b0;
      probe_seen   = 1'b0;
      dur_code     = DUR_RESET;
      duty         = DUTY_RESET;
      res1_held    = 8'd0;
      ticks        = 0;
      open_cnt     = 0;
      short_cnt    = 0;
      good_cnt     = 0;
    endfunction

    function int unsigned unit_of(int unsigned e);
      return (e == 0) ? 10 : ((e == 1) ? 100 : 1000);
    endfunction

    function int unsigned dur_to_us(logic [6:0] b);
      int unsigned e, f;
      e = 32'(b[6:5]);
      f = 32'(b[4:0]);
      if (e > 2) e = 2;
      if (f > 19) f = 19;
      return unit_of(e) * f / 20;
    endfunction

    // Smallest exponent whose fraction represents the duration exactly.
    function logic [6:0] us_to_dur(int unsigned us);
      int unsigned m, f;
      for (int unsigned e = 0; e <= 2; e++) begin
        m = unit_of(e);
        f = us * 20 / m;
        if (f >= 1 && f <= 19 && m * f / 20 == us) return {e[1:0], f[4:0]};
      end
      return 7'd0;
    endfunction

    function void clamp_duty_bound();
      logic [7:0] hi;
      hi = !high_current ? 8'd22 : ((dur_to_us(dur_code) >= 100) ? 8'd124 : 8'd47);
      if (duty < DUTY_MIN) duty = DUTY_MIN;
      if (duty > hi) duty = hi;
    endfunction

    function void clamp_duration();
      int unsigned us;
      us = dur_to_us(dur_code);
      if (!high_current) us = 10;
      else if (us < 25) us = 25;
      else if (us > 950) us = 950;
      dur_code = us_to_dur(us);
      clamp_duty_bound();
    endfunction

    function void bus_write(logic [7:0] addr, logic [7:0] v);
      if (addr == A_CTRL) begin
        if (!v[0]) begin
          run_flag = 1'b0;
        end else if (!run_flag && !fault_sticky) begin
          run_flag   = 1'b1;
          ticks      = 0;
          probe_seen = 1'b0;
          open_cnt   = 0;
          short_cnt  = 0;
          good_cnt   = 0;
        end
      end else if (addr == A_FAULT) begin
        if (v[1]) wdog_latched = 1'b0;
      end else if (!run_flag) begin
        case (addr)
          A_MODE: cut_mode = v[0];
          A_CURR: begin
            high_current = (v > 8'd5);
            clamp_duration();
          end
          A_DUR: begin
            dur_code = v[6:0];
            clamp_duration();
          end
          A_DUTY: begin
            duty = v;
            clamp_duty_bound();
          end
          default: ;
        endcase
      end
    endfunction

    // Result register read: live ratios in cut mode, probe flag otherwise.
    function logic [7:0] read_result0();
      int unsigned n, ro, rs;
      logic [7:0]  r;
      if (!cut_mode) begin
        r         = {7'd0, probe_seen};
        res1_held = 8'd0;
      end else begin
        n  = open_cnt + short_cnt + good_cnt;
        ro = 7;
        rs = 0;
        if (n != 0) begin
          ro = open_cnt * 7 / n;
          rs = short_cnt * 7 / n;
        end
        r         = {2'd0, ro[2:0], rs[2:0]};
        res1_held = (good_cnt > 255) ? 8'd255 : good_cnt[7:0];
        open_cnt  = 0;
        short_cnt = 0;
        good_cnt  = 0;
      end
      ticks = 0;
      return r | {fault_sticky, 7'd0};
    endfunction

    function logic [7:0] bus_read(logic [7:0] addr);
      case (addr)
        A_CTRL:  return {7'd0, run_flag};
        A_MODE:  return {7'd0, cut_mode};
        A_CURR:  return high_current ? 8'd10 : 8'd1;
        A_DUR:   return {1'b0, dur_code};
        A_DUTY:  return duty;
        A_RES0:  return read_result0();
        A_RES1:  return res1_held;
        A_FAULT: return {6'd0, wdog_latched, fault_sticky};
        default: return 8'd0;
      endcase
    endfunction

    // Called for every accepted input beat.
    function void note_item(logic [2:0] kind, logic [7:0] addr, logic [7:0] wdata,
                            logic [1:0] outcome, logic conducted);
      pulser_result_t r;
      r.read_data = 8'd0;
      case (kind)
        KIND_WRITE: bus_write(addr, wdata);
        KIND_READ:  r.read_data = bus_read(addr);
        KIND_CUT: begin
          if (run_flag && cut_mode) begin
            if (outcome == OUT_OPEN && open_cnt < COUNT_MAX) open_cnt++;
            else if (outcome == OUT_SHORT && short_cnt < COUNT_MAX) short_cnt++;
            else if (outcome == OUT_GOOD && good_cnt < COUNT_MAX) good_cnt++;
          end
        end
        KIND_PROBE: begin
          if (run_flag && !cut_mode && conducted) begin
            probe_seen = 1'b1;
            run_flag   = 1'b0;
          end
        end
        KIND_TICK: begin
          if (ticks < 32'hffff) ticks++;
          if (run_flag && ticks >= wdog_timeout) begin
            wdog_latched = 1'b1;
            run_flag     = 1'b0;
          end
        end
        KIND_FAULT: begin
          fault_sticky = 1'b1;
          run_flag     = 1'b0;
        end
        default: ;
      endcase
      r.running      = run_flag;
      r.cut_mode     = cut_mode;
      r.high_current = high_current;
      r.duration_us  = 10'(dur_to_us(dur_code));
      r.duty         = duty;
      expected_q.push_back(r);
    endfunction

    // Called for every accepted result beat.
    function void check_beat(logic [31:0] data);
      pulser_result_t got, want;
      got = data[28:0];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", data);
        return;
      end
      want = expected_q.pop_front();
      if (data[31:29] != 3'd0 || got.read_data !== want.read_data ||
          got.running !== want.running || got.cut_mode !== want.cut_mode ||
          got.high_current !== want.high_current ||
          got.duration_us !== want.duration_us || got.duty !== want.duty) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: rd %h/%h run %b/%b cut %b/%b hi %b/%b dur %0d/%0d duty %0d/%0d",
                   want.read_data, got.read_data, want.running, got.running,
                   want.cut_mode, got.cut_mode, want.high_current, got.high_current,
                   want.duration_us, got.duration_us, want.duty, got.duty);
        end
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  pulser_scoreboard sb;
  logic             no_idle;
  int unsigned      items_sent;

  pulser_control_registers dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Send one item beat, with an occasional gap before it.
  task automatic send_item(logic [2:0] kind, logic [7:0] addr, logic [7:0] wdata,
                           logic [1:0] outcome, logic conducted);
    int unsigned gap;
    gap = (!no_idle && $urandom_range(99) < 17) ? $urandom_range(4, 1) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'd0, conducted, outcome, wdata, addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(kind, addr, wdata, outcome, conducted);
    items_sent++;
  endtask

  task automatic reg_write(logic [7:0] addr, logic [7:0] v);
    send_item(KIND_WRITE, addr, v, 2'($urandom), 1'($urandom));
  endtask

  task automatic reg_read(logic [7:0] addr);
    send_item(KIND_READ, addr, 8'($urandom), 2'($urandom), 1'($urandom));
  endtask

  task automatic event_item(logic [2:0] kind, logic [1:0] outcome, logic conducted);
    send_item(kind, 8'($urandom), 8'($urandom), outcome, conducted);
  endtask

  // Let the block drain, then program the watchdog timeout over APB.
  task automatic set_timeout(logic [15:0] ticks);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= {16'($urandom), ticks} & 32'h0000ffff | {$urandom_range(1) ? 16'hffff : 16'h0, 16'h0};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.wdog_timeout = ticks;
    @(posedge clk_i);
  endtask

  // One well-formed run: setup while stopped, start, activity, wrap-up reads and a stop.
  task automatic run_session();
    int unsigned body;
    int unsigned pick;
    logic [7:0]  addrs [8];
    addrs = '{A_CTRL, A_MODE, A_CURR, A_DUR, A_DUTY, A_RES0, A_RES1, A_FAULT};
    repeat ($urandom_range(4)) begin
      case ($urandom_range(3))
        0: reg_write(A_MODE, 8'($urandom));
        1: reg_write(A_CURR, $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom));
        2: reg_write(A_DUR, 8'($urandom));
        default: reg_write(A_DUTY, 8'($urandom));
      endcase
    end
    reg_write(A_CTRL, 8'($urandom) | 8'h01);
    body = $urandom_range(30, 8);
    repeat (body) begin
      pick = $urandom_range(99);
      if (pick < 40) event_item(KIND_CUT, ($urandom_range(9) == 0) ? 2'd3 :
                                2'($urandom_range(2)), 1'($urandom));
      else if (pick < 48) event_item(KIND_PROBE, 2'($urandom), 1'($urandom));
      else if (pick < 62) event_item(KIND_TICK, 2'($urandom), 1'($urandom));
      else if (pick < 78) reg_read(addrs[$urandom_range(7)]);
      else if (pick < 86) reg_write(addrs[$urandom_range(7)], 8'($urandom));
      else if (pick < 90) reg_write(A_CTRL, 8'($urandom));
      else if (pick < 95) send_item(3'($urandom_range(7, 6)), 8'($urandom), 8'($urandom),
                                    2'($urandom), 1'($urandom));
      else send_item(3'($urandom_range(1)), 8'($urandom), 8'($urandom),
                     2'($urandom), 1'($urandom));
    end
    reg_read(A_RES0);
    reg_read(A_RES1);
    if ($urandom_range(1)) reg_read(A_FAULT);
    if ($urandom_range(1)) reg_write(A_FAULT, 8'($urandom));
    reg_write(A_CTRL, 8'($urandom) & 8'hfe);
  endtask

  // Result side: check accepted beats and stall at random.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
      m_axis_tready <= no_idle || ($urandom_range(99) >= 17);
    end
  end

  // Main sequence.
  initial begin
    sb            = new();
    no_idle       = 1'b0;
    items_sent    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset values, clamp extremes, counters, unknown codes.
    reg_read(A_DUR);
    reg_read(A_CURR);
    reg_read(A_RES0);
    reg_write(A_CURR, 8'd5);
    reg_write(A_DUTY, 8'd255);
    reg_write(A_CURR, 8'd255);
    reg_write(A_DUR, 8'h7f);
    reg_write(A_DUTY, 8'd255);
    reg_write(A_DUR, 8'h00);
    reg_write(A_DUTY, 8'd0);
    reg_write(A_DUR, 8'h3f);
    reg_write(A_MODE, 8'h01);
    reg_read(A_RES0);
    reg_write(A_CTRL, 8'h01);
    event_item(KIND_CUT, OUT_OPEN, 1'b0);
    event_item(KIND_CUT, OUT_SHORT, 1'b1);
    event_item(KIND_CUT, OUT_GOOD, 1'b0);
    event_item(KIND_CUT, 2'd3, 1'b1);
    reg_write(A_DUTY, 8'd10);
    reg_read(A_RES0);
    reg_read(A_RES1);
    send_item(3'd6, 8'hff, 8'hff, 2'd3, 1'b1);
    send_item(3'd7, 8'h00, 8'h00, 2'd0, 1'b0);
    reg_write(8'hff, 8'hff);
    reg_read(8'hff);
    reg_write(A_CTRL, 8'h00);

    // Shortest timeout: the first tick of a run trips the watchdog.
    set_timeout(16'd1);
    reg_write(A_MODE, 8'h00);
    reg_write(A_CTRL, 8'h01);
    event_item(KIND_TICK, 2'd0, 1'b0);
    reg_read(A_FAULT);
    reg_write(A_CTRL, 8'h01);
    reg_write(A_FAULT, 8'h02);
    reg_read(A_FAULT);
    while (items_sent < 120) run_session();

    // Short timeouts with a stretch free of idling on both sides.
    set_timeout(16'($urandom_range(12, 2)));
    no_idle = 1'b1;
    while (items_sent < 190) run_session();
    no_idle = 1'b0;
    while (items_sent < 240) run_session();

    // Longest timeout.
    set_timeout(16'hffff);
    while (items_sent < 280) run_session();

    // More good windows than RES1 can show: the latch clamps at 255.
    no_idle = 1'b1;
    reg_write(A_CTRL, 8'h00);
    reg_write(A_MODE, 8'h01);
    reg_write(A_CTRL, 8'h01);
    repeat (260) event_item(KIND_CUT, OUT_GOOD, 1'b0);
    event_item(KIND_CUT, OUT_OPEN, 1'b0);
    event_item(KIND_CUT, OUT_SHORT, 1'b0);
    reg_read(A_RES0);
    reg_read(A_RES1);
    no_idle = 1'b0;

    // Fault is sticky: it stops the run and blocks any later start.
    set_timeout(16'd1000);
    reg_write(A_CTRL, 8'h01);
    event_item(KIND_FAULT, 2'd0, 1'b0);
    reg_write(A_CTRL, 8'h01);
    reg_read(A_CTRL);
    reg_read(A_RES0);
    reg_read(A_FAULT);
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pcr_pkg.sv
hw/rtl/pcr_ctrl.sv
hw/rtl/pcr_datapath.sv
hw/rtl/pulser_control_registers.sv
test/tb_pulser_control_registers.sv
